// ===== rtl/core/ispd_pkg.sv =====
// Types and constants shared by the inertial sensor packet decoder.
package ispd_pkg;

  localparam int unsigned POS_W       = 6;
  localparam int unsigned FRM_W       = 2;
  localparam int unsigned OFF_W       = 4;
  localparam int unsigned FRAME_COUNT = 3;
  localparam int unsigned AXIS_COUNT  = 9;
  localparam int unsigned AXIS_IDX_W  = 4;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] ACCEL_TYPE = 8'h51;

  // Expected type byte of each frame: acceleration, angular rate, angle.
  localparam logic [7:0] FRAME_TYPE [FRAME_COUNT] = '{8'h51, 8'h52, 8'h53};

  // Byte offsets within one 11-byte frame.
  localparam logic [OFF_W-1:0] OFF_SYNC  = 4'd0;
  localparam logic [OFF_W-1:0] OFF_TYPE  = 4'd1;
  localparam logic [OFF_W-1:0] OFF_SUMS  = 4'd10;
  localparam logic [OFF_W-1:0] OFF_CSUM  = 4'd10;
  localparam logic [OFF_W-1:0] OFF_LAST  = 4'd10;
  localparam logic [FRM_W-1:0] FRM_TRAIL = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic               accel_fresh;
    logic               rate_fresh;
    logic               angle_fresh;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } res_word_t;

endpackage

// ===== rtl/core/ispd_stream_if.sv =====
// Valid/ready stream interface carrying one word of a given payload type.
interface ispd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/imu_serial_packet_decoder_core.sv =====
// Decoder that turns the byte stream of an inertial sensor into axis records.
//
// Usage: bytes from the sensor's serial link arrive one word at a time on
// rx_i (valid/ready, a word moves when both are high). Every PACKET_LENGTH
// bytes that open with the header 0x55 0x51 produce one word on res_o: the
// held acceleration, angular rate and angle axis counts, and one fresh flag
// for each of the three frames whose type byte and checksum matched. A bad
// header drops the packet and the count restarts at the next byte.
// Timing: a byte is registered at the input, then processed by a single
// pass of adders and compares; the result of a packet's last byte is
// registered in the output register on res_o. One byte can be accepted
// in every cycle unless a stalled receiver leaves both registers full.
// Reset clears the byte count, the checksum, the frame flags and the held
// axis values to zero; the axis staging registers are not cleared.
// When the receiver stalls, the pending result waits in the output register
// and the input register still takes one byte; further bytes are held off
// only while both registers are full.
module imu_serial_packet_decoder_core #(
  parameter int unsigned PACKET_LENGTH = 44
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ispd_stream_if.sink   rx_i,
  ispd_stream_if.source res_o
);
  import ispd_pkg::*;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Decode state.
  logic [POS_W-1:0] pos_q, pos_d;
  logic [FRM_W-1:0] frm_q, frm_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [7:0]       sum_q, sum_d;
  logic [FRAME_COUNT-1:0] ok_q, ok_d;
  logic [7:0]       low_q, low_d;
  logic [15:0]      stg_q  [AXIS_COUNT];
  logic [15:0]      held_q [AXIS_COUNT];
  logic [15:0]      held_d [AXIS_COUNT];

  // Output register.
  logic      out_valid_q;
  res_word_t out_data_q, out_data_d;

  logic                  out_free;
  logic                  proc;
  logic                  in_frame;
  logic                  hdr_bad;
  logic                  last;
  logic                  stg_we;
  logic [AXIS_IDX_W-1:0] stg_idx;
  logic [7:0]            b;

  // The byte in the input register moves on whenever the output register
  // is empty or is being emptied in this cycle.
  assign out_free   = !out_valid_q || res_o.ready;
  assign proc       = s1_valid_q && out_free;
  assign rx_i.ready = !s1_valid_q || out_free;
  assign b          = s1_byte_q;
  assign in_frame   = (frm_q != FRM_TRAIL);
  assign last       = (pos_q == POS_W'(PACKET_LENGTH - 1));

  // Axis word k of a frame completes at offsets 3, 5 and 7; bits 2:1 of the
  // offset minus one give k, and the frame number gives the group of three.
  assign stg_idx = AXIS_IDX_W'(frm_q) * AXIS_IDX_W'(3)
                 + AXIS_IDX_W'(off_q[2:1]) - AXIS_IDX_W'(1);

  always_comb begin
    pos_d   = pos_q;
    frm_d   = frm_q;
    off_d   = off_q;
    sum_d   = sum_q;
    ok_d    = ok_q;
    low_d   = low_q;
    stg_we  = 1'b0;
    hdr_bad = 1'b0;
    held_d  = held_q;
    if (proc) begin
      if (pos_q == '0) begin
        ok_d = '0;
      end
      // The second byte decides whether this is a packet at all: the first
      // byte sits in the running sum at that point.
      if (pos_q == POS_W'(1) && (sum_q != SYNC_BYTE || b != ACCEL_TYPE)) begin
        hdr_bad = 1'b1;
        pos_d   = '0;
        frm_d   = '0;
        off_d   = '0;
      end else begin
        if (in_frame) begin
          if (off_q == OFF_SYNC) begin
            sum_d = b;
          end else if (off_q < OFF_SUMS) begin
            sum_d = sum_q + b;
          end
          if (off_q == OFF_TYPE) begin
            ok_d[frm_q] = (b == FRAME_TYPE[frm_q]);
          end
          if (off_q inside {4'd2, 4'd4, 4'd6}) begin
            low_d = b;
          end
          if (off_q inside {4'd3, 4'd5, 4'd7}) begin
            stg_we = 1'b1;
          end
          if (off_q == OFF_CSUM && b != sum_q) begin
            ok_d[frm_q] = 1'b0;
          end
        end
        if (last) begin
          // Copy every frame that passed both checks into the held values.
          for (int f = 0; f < FRAME_COUNT; f++) begin
            if (ok_d[f]) begin
              for (int k = 0; k < 3; k++) begin
                held_d[f*3+k] = stg_q[f*3+k];
              end
            end
          end
          pos_d = '0;
          frm_d = '0;
          off_d = '0;
        end else begin
          pos_d = pos_q + POS_W'(1);
          if (in_frame) begin
            if (off_q == OFF_LAST) begin
              off_d = '0;
              frm_d = frm_q + FRM_W'(1);
            end else begin
              off_d = off_q + OFF_W'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_data_d.accel_fresh = ok_d[0];
    out_data_d.rate_fresh  = ok_d[1];
    out_data_d.angle_fresh = ok_d[2];
    out_data_d.accel_x     = held_d[0];
    out_data_d.accel_y     = held_d[1];
    out_data_d.accel_z     = held_d[2];
    out_data_d.rate_x      = held_d[3];
    out_data_d.rate_y      = held_d[4];
    out_data_d.rate_z      = held_d[5];
    out_data_d.roll_angle  = held_d[6];
    out_data_d.pitch_angle = held_d[7];
    out_data_d.yaw_angle   = held_d[8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      frm_q       <= '0;
      off_q       <= '0;
      sum_q       <= '0;
      ok_q        <= '0;
      low_q       <= '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (proc && last) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      pos_q  <= pos_d;
      frm_q  <= frm_d;
      off_q  <= off_d;
      sum_q  <= sum_d;
      ok_q   <= ok_d;
      low_q  <= low_d;
      held_q <= held_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      s1_byte_q <= rx_i.data.rx_byte;
    end
    if (proc && last) begin
      out_data_q <= out_data_d;
    end
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (stg_we && stg_idx == AXIS_IDX_W'(i)) begin
        stg_q[i] <= {b, low_q};
      end
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

  // The byte count never reaches the packet length.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(PACKET_LENGTH))
    else $error("byte position beyond packet length");

  // Frame and offset counters restart together with the byte count.
  a_counters_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == '0 |-> (frm_q == '0 && off_q == '0))
    else $error("frame counters not aligned with packet start");

  // Processing the last byte of a packet always leaves a result waiting.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last) |=> (out_valid_q && pos_q == '0))
    else $error("packet end did not produce a result");

  // A rejected header restarts the count without producing a result.
  a_bad_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && hdr_bad) |=> (pos_q == '0 && !$rose(out_valid_q)))
    else $error("bad header not handled");

endmodule

// ===== sim/ispd_packet_checker.sv =====
// Checker that predicts the decoder's axis records and compares them with the outputs.
module ispd_packet_checker
  import ispd_pkg::*;
#(
  parameter int unsigned PKT_LEN = 44
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  input  logic      rx_ready_i,
  input  rx_word_t  rx_word_i,
  input  logic      res_valid_i,
  input  logic      res_ready_i,
  input  res_word_t res_word_i,
  output int        awaited_o,
  output int        mismatches_o
);

  localparam int unsigned FRAME_LEN  = 11;
  localparam int unsigned SUM_LEN    = 10;
  localparam int unsigned FRAMED_LEN = FRAME_LEN * FRAME_COUNT;

  logic [POS_W-1:0]       byte_pos;
  logic [7:0]             frame_sum;
  logic [FRAME_COUNT-1:0] frame_ok;
  logic [7:0]             low_hold;
  logic [15:0]            staged_counts [AXIS_COUNT];
  logic signed [15:0]     held_counts [AXIS_COUNT];

  res_word_t              awaited_records [$];
  int                     mismatch_total;

  // Advances the predicted decoder by one received byte; a completed packet
  // queues the record that the block should emit for it.
  task automatic decode_byte(input logic [7:0] rx_b);
    int unsigned f;
    int unsigned o;
    res_word_t   rec;
    if (byte_pos == 0) frame_ok = '0;
    if (byte_pos == 1 && (frame_sum != SYNC_BYTE || rx_b != ACCEL_TYPE)) begin
      byte_pos = '0;
      return;
    end
    if (byte_pos < FRAMED_LEN) begin
      f = byte_pos / FRAME_LEN;
      o = byte_pos % FRAME_LEN;
      if (o == 0) frame_sum = rx_b;
      else if (o < SUM_LEN) frame_sum = frame_sum + rx_b;
      if (o == OFF_TYPE) frame_ok[f] = (rx_b == FRAME_TYPE[f]);
      // Axis words arrive low byte first at offsets 2 to 7.
      if (o == 2 || o == 4 || o == 6) low_hold = rx_b;
      if (o == 3 || o == 5 || o == 7) staged_counts[f * 3 + (o - 3) / 2] = {rx_b, low_hold};
      if (o == OFF_CSUM && rx_b != frame_sum) frame_ok[f] = 1'b0;
    end
    if (byte_pos + 1 < PKT_LEN) begin
      byte_pos = byte_pos + 1'b1;
      return;
    end
    for (int k = 0; k < AXIS_COUNT; k++)
      if (frame_ok[k / 3]) held_counts[k] = staged_counts[k];
    rec.accel_fresh = frame_ok[0];
    rec.rate_fresh  = frame_ok[1];
    rec.angle_fresh = frame_ok[2];
    rec.accel_x     = held_counts[0];
    rec.accel_y     = held_counts[1];
    rec.accel_z     = held_counts[2];
    rec.rate_x      = held_counts[3];
    rec.rate_y      = held_counts[4];
    rec.rate_z      = held_counts[5];
    rec.roll_angle  = held_counts[6];
    rec.pitch_angle = held_counts[7];
    rec.yaw_angle   = held_counts[8];
    awaited_records.push_back(rec);
    byte_pos = '0;
  endtask

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (want !== got) begin
      if (mismatch_total < 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endtask

  task automatic check_record(input res_word_t got);
    res_word_t want;
    if (awaited_records.size() == 0) begin
      if (mismatch_total < 10) $display("result word arrived with none expected");
      mismatch_total++;
      return;
    end
    want = awaited_records.pop_front();
    check_field("accel_fresh", want.accel_fresh, got.accel_fresh);
    check_field("rate_fresh", want.rate_fresh, got.rate_fresh);
    check_field("angle_fresh", want.angle_fresh, got.angle_fresh);
    check_field("accel_x", want.accel_x, got.accel_x);
    check_field("accel_y", want.accel_y, got.accel_y);
    check_field("accel_z", want.accel_z, got.accel_z);
    check_field("rate_x", want.rate_x, got.rate_x);
    check_field("rate_y", want.rate_y, got.rate_y);
    check_field("rate_z", want.rate_z, got.rate_z);
    check_field("roll_angle", want.roll_angle, got.roll_angle);
    check_field("pitch_angle", want.pitch_angle, got.pitch_angle);
    check_field("yaw_angle", want.yaw_angle, got.yaw_angle);
  endtask

  initial mismatch_total = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_pos  = '0;
      frame_sum = '0;
      frame_ok  = '0;
      low_hold  = '0;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        staged_counts[k] = '0;
        held_counts[k]   = '0;
      end
      awaited_records.delete();
    end else begin
      // A result leaves after its last byte has passed the output register,
      // so it is compared before the byte of the same edge is predicted.
      if (res_valid_i && res_ready_i) check_record(res_word_i);
      if (rx_valid_i && rx_ready_i) decode_byte(rx_word_i.rx_byte);
    end
    awaited_o    <= awaited_records.size();
    mismatches_o <= mismatch_total;
  end

endmodule

// ===== sim/imu_serial_packet_decoder_core_tb.sv =====
// Testbench top: drives sensor byte streams into the packet decoder and gives the verdict.
module imu_serial_packet_decoder_core_tb;
  import ispd_pkg::*;

  localparam int unsigned PKT_LEN      = 44;
  localparam int unsigned FRAME_LEN    = 11;
  localparam int unsigned SUM_LEN      = 10;
  localparam int unsigned FRAMED_LEN   = FRAME_LEN * FRAME_COUNT;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned QUIET_FROM   = 1550;
  localparam int unsigned STALL_LIMIT  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Axis counts at the edges of the signed 16-bit range, and around zero.
  localparam logic [15:0] AXIS_EDGES [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};

  logic clk;
  logic rst_n;

  ispd_stream_if #(.payload_t(rx_word_t))  rx_if ();
  ispd_stream_if #(.payload_t(res_word_t)) res_if ();

  imu_serial_packet_decoder_core #(
    .PACKET_LENGTH(PKT_LEN)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  int awaited;
  int mismatches;

  ispd_packet_checker #(
    .PKT_LEN(PKT_LEN)
  ) pkt_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_valid_i  (rx_if.valid),
    .rx_ready_i  (rx_if.ready),
    .rx_word_i   (rx_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_word_i  (res_if.data),
    .awaited_o   (awaited),
    .mismatches_o(mismatches)
  );

  // Bytes of the packet being sent, and the sender's own idea of where the
  // decoder stands in its packet, so that noise can be followed by padding
  // that brings it back to the start of a packet.
  logic [7:0]  packet_bytes [PKT_LEN];
  int unsigned stream_pos;
  logic [7:0]  first_byte;
  int unsigned words_sent;
  int unsigned packets_sent;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  // One chance in gap_odds per word of an idle burst on either side; zero
  // means a stretch with no idling at all.
  int unsigned gap_odds;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in bursts, changing its ready at the falling edge only.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      res_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 5);
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // Watchdog: a run of cycles in which no word moves on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_axis();
    if ($urandom_range(0, 9) == 0) return AXIS_EDGES[$urandom_range(0, 3)];
    return 16'($urandom);
  endfunction

  // Offers one byte, holding it until the decoder takes it. An idle burst may
  // come first, with valid low for the whole burst.
  task automatic send_byte(input logic [7:0] rx_b);
    int unsigned gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      @(negedge clk);
      rx_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_if.valid        = 1'b1;
    rx_if.data.rx_byte = rx_b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    words_sent++;
    // Track the packet position the way the decoder counts: the header is
    // judged at the second byte, and a bad one restarts the count.
    if (stream_pos == 0) begin
      first_byte = rx_b;
      stream_pos = 1;
    end else if (stream_pos == 1) begin
      stream_pos = (first_byte == SYNC_BYTE && rx_b == ACCEL_TYPE) ? 2 : 0;
    end else begin
      stream_pos = (stream_pos + 1 == PKT_LEN) ? 0 : stream_pos + 1;
    end
  endtask

  // Fills packet_bytes with three frames and a random tail. A set bit in
  // type_bad or sum_bad spoils that frame's type byte or checksum. edge_rot
  // selects a rotation of range-edge axis counts, or random counts if negative.
  task automatic build_packet(input logic [2:0] type_bad, input logic [2:0] sum_bad,
                              input logic [7:0] mid_sync, input int edge_rot);
    int unsigned base;
    logic [15:0] axis;
    logic [7:0]  csum;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      base = f * FRAME_LEN;
      packet_bytes[base]     = (f == 0) ? SYNC_BYTE : mid_sync;
      packet_bytes[base + 1] = type_bad[f] ? FRAME_TYPE[f] ^ 8'($urandom_range(1, 255))
                                           : FRAME_TYPE[f];
      for (int k = 0; k < 3; k++) begin
        axis = (edge_rot < 0) ? pick_axis() : AXIS_EDGES[(f * 3 + k + edge_rot) % 4];
        packet_bytes[base + 2 + 2 * k] = axis[7:0];
        packet_bytes[base + 3 + 2 * k] = axis[15:8];
      end
      packet_bytes[base + 8] = 8'($urandom);
      packet_bytes[base + 9] = 8'($urandom);
      csum = '0;
      for (int i = 0; i < SUM_LEN; i++) csum = csum + packet_bytes[base + i];
      if (sum_bad[f]) csum = csum + 8'($urandom_range(1, 255));
      packet_bytes[base + OFF_CSUM] = csum;
    end
    for (int i = FRAMED_LEN; i < PKT_LEN; i++) packet_bytes[i] = 8'($urandom);
  endtask

  // Sends whatever is in packet_bytes and then zero bytes until the decoder
  // is back at the start of a packet; a zero at the second position is a bad
  // header, so the padding never leaves it half way into a header.
  task automatic send_packet_and_align();
    for (int i = 0; i < PKT_LEN; i++) send_byte(packet_bytes[i]);
    while (stream_pos != 0) send_byte(8'h00);
  endtask

  task automatic align_stream();
    while (stream_pos != 0) send_byte(8'h00);
  endtask

  initial begin
    int unsigned kind;
    int unsigned noise_len;
    logic [2:0]  type_bad;
    logic [2:0]  sum_bad;
    logic [7:0]  mid_sync;
    logic [7:0]  head_b;

    rst_n              = 1'b0;
    rx_if.valid        = 1'b0;
    rx_if.data.rx_byte = '0;
    stream_pos         = 0;
    first_byte         = '0;
    words_sent         = 0;
    packets_sent       = 0;
    gap_odds           = 5;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. First, fully valid packets whose axes sit at the edges
    // of the signed range.
    build_packet(3'b000, 3'b000, SYNC_BYTE, 0);
    send_packet_and_align();
    build_packet(3'b000, 3'b000, SYNC_BYTE, 2);
    send_packet_and_align();
    // A wrong rate type and a wrong angle checksum: those axes stay held.
    build_packet(3'b010, 3'b100, SYNC_BYTE, -1);
    send_packet_and_align();
    // The start byte of the second and third frames is only summed, never
    // tested on its own.
    build_packet(3'b000, 3'b000, 8'hAA, -1);
    send_packet_and_align();
    // Bad headers: wrong first byte, wrong second byte, and a start byte in
    // the second position, which must not open a new packet.
    send_byte(8'h12);
    send_byte(ACCEL_TYPE);
    send_byte(SYNC_BYTE);
    send_byte(8'h52);
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    build_packet(3'b000, 3'b001, SYNC_BYTE, -1);
    send_packet_and_align();
    // Every frame invalid, then a valid packet at the other edge rotation.
    build_packet(3'b110, 3'b001, SYNC_BYTE, -1);
    send_packet_and_align();
    build_packet(3'b000, 3'b000, SYNC_BYTE, 1);
    send_packet_and_align();

    // Random part: mostly well-formed packets with random content, the rest
    // bad headers, loose noise and packets that fail at the header.
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= QUIET_FROM) begin
        gap_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_odds = 0;
          1:       gap_odds = 3;
          2:       gap_odds = 8;
          default: gap_odds = 20;
        endcase
      end

      // Once, the sender holds back until every pending record has left.
      if (packets_sent == 12) begin
        @(negedge clk);
        rx_if.valid = 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        for (int f = 0; f < FRAME_COUNT; f++) begin
          type_bad[f] = (f != 0) && ($urandom_range(0, 7) == 0);
          sum_bad[f]  = ($urandom_range(0, 7) == 0);
        end
        mid_sync = ($urandom_range(0, 6) == 0) ? 8'($urandom) : SYNC_BYTE;
        build_packet(type_bad, sum_bad, mid_sync, -1);
        send_packet_and_align();
      end else if (kind < 82) begin
        head_b = $urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom);
        send_byte(head_b);
        if (head_b == SYNC_BYTE) send_byte(ACCEL_TYPE ^ 8'($urandom_range(1, 255)));
        else send_byte($urandom_range(0, 1) ? ACCEL_TYPE : 8'($urandom));
        align_stream();
      end else if (kind < 92) begin
        noise_len = $urandom_range(1, 60);
        repeat (noise_len) send_byte(8'($urandom));
        align_stream();
      end else begin
        // The acceleration type byte is also the second header byte, so a
        // wrong one drops the packet and the rest is taken as fresh bytes.
        build_packet(3'b001, 3'b000, SYNC_BYTE, -1);
        send_packet_and_align();
      end
      packets_sent++;
    end

    @(negedge clk);
    rx_if.valid = 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
